/* sv/bfw_pkg.sv */
// ----------------------------------------------------------------------------
// bfw_pkg
// Shared types and constants of the bilateral filter window unit.
// ----------------------------------------------------------------------------
package bfw_pkg;

  localparam int unsigned DEF_MAX_RADIUS = 3;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_PIXEL_BITS = 8;
  localparam int unsigned HEIGHT_LIMIT   = 4096;

  typedef enum logic [1:0] {
    REQ_PIXEL   = 2'd0,
    REQ_FLUSH   = 2'd1,
    REQ_SPATIAL = 2'd2,
    REQ_RANGE   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_ENABLE = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_EMIT,
    ST_CENTER,
    ST_TAP_ADDR,
    ST_TAP_READ,
    ST_TAP_RANGE,
    ST_TAP_MUL,
    ST_TAP_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* sv/bilateral_filter_window_unit.sv */
// ----------------------------------------------------------------------------
// bilateral_filter_window_unit
// Streaming joint bilateral filter over a square window with line stores.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake               | Payload
// in_     | in  | in_tvalid / in_tready   | in_tdata, in_tuser (req_type)
// out_    | out | out_tvalid / out_tready | out_tdata, out_tlast, out_tuser
// cfg_    | in  | APB, pready tied high   | four 32-bit registers
//
// An item is taken only in IDLE. Table writes and pixel items without a result
// return to IDLE after WRITE; a pixel that gives a pass-through result goes
// from the centre read in CENTER to DONE. A filtered pixel walks every window
// tap through the single line store read port and the prod_r product register,
// then a one-bit-per-cycle divider runs (skipped when the weight sum is zero).
// Reset is synchronous, active low, and clears the counters and the valid bits
// of the weight tables; the line stores hold no reset state.
// A stalled result holds the block in DONE until out_tready.
// ----------------------------------------------------------------------------
module bilateral_filter_window_unit #(
  parameter int unsigned MAX_RADIUS = bfw_pkg::DEF_MAX_RADIUS,
  parameter int unsigned MAX_WIDTH  = bfw_pkg::DEF_MAX_WIDTH,
  parameter int unsigned PIXEL_BITS = bfw_pkg::DEF_PIXEL_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // src_pixel, ref_pixel, table_index, weight_value, zero pad
  input  logic [2*PIXEL_BITS+24+((8-((2*PIXEL_BITS+24)%8))%8)-1:0] in_tdata,
  // req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_pixel, zero pad
  output logic [PIXEL_BITS+((8-(PIXEL_BITS%8))%8)-1:0] out_tdata,
  output logic        out_tlast,
  // zero_weight
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bfw_pkg::*;

  localparam int unsigned PB      = PIXEL_BITS;
  localparam int unsigned RING    = 2 * MAX_RADIUS + 1;
  localparam int unsigned RW      = $clog2(RING);
  localparam int unsigned CW      = $clog2(MAX_WIDTH);
  localparam int unsigned MW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW      = $clog2(HEIGHT_LIMIT + 1);
  localparam int unsigned DEPTH   = RING * MAX_WIDTH;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned SDEPTH  = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
  localparam int unsigned SW      = $clog2(SDEPTH);
  localparam int unsigned RDEPTH  = 1 << PB;
  localparam int unsigned RADW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned TAPS    = RING * RING;
  localparam int unsigned WSW     = 16 + $clog2(TAPS + 1);
  localparam int unsigned ACW     = WSW + PB;
  localparam int unsigned DCW     = $clog2(ACW + 1);
  localparam int unsigned OFFW    = RADW + 1;
  localparam logic [PB-1:0] PMAX  = {PB{1'b1}};

  // ---------------- configuration ----------------
  logic [1:0]  radius_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic        enable_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 2'd1;
      width_r  <= 11'd1024;
      height_r <= 13'd768;
      enable_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (reg_index_t'(cfg_paddr[3:2]))
        REG_RADIUS: radius_r <= cfg_pwdata[1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[10:0];
        REG_HEIGHT: height_r <= cfg_pwdata[12:0];
        REG_ENABLE: enable_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_index_t'(cfg_paddr[3:2]))
      REG_RADIUS: cfg_prdata[1:0]  = radius_r;
      REG_WIDTH:  cfg_prdata[10:0] = width_r;
      REG_HEIGHT: cfg_prdata[12:0] = height_r;
      REG_ENABLE: cfg_prdata[0]    = enable_r;
      default: ;
    endcase
  end

  // Effective (saturated) geometry.
  logic [RADW-1:0] eff_r;
  logic [MW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;
  logic            cfg_hit;

  always_comb begin
    if (32'(radius_r) > MAX_RADIUS) eff_r = RADW'(MAX_RADIUS);
    else eff_r = RADW'(radius_r);
    if (width_r == '0) eff_w = MW'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = MW'(MAX_WIDTH);
    else eff_w = MW'(width_r);
    if (height_r == '0) eff_h = HW'(1);
    else if (32'(height_r) > HEIGHT_LIMIT) eff_h = HW'(HEIGHT_LIMIT);
    else eff_h = HW'(height_r);
  end

  assign cfg_hit = cfg_wr && cfg_paddr[1:0] == 2'b00;

  // ---------------- input fields ----------------
  logic [PB-1:0] in_src, in_ref;
  logic [7:0]    in_idx;
  logic [15:0]   in_wt;
  assign in_src = in_tdata[PB-1:0];
  assign in_ref = in_tdata[2*PB-1:PB];
  assign in_idx = in_tdata[2*PB+7:2*PB];
  assign in_wt  = in_tdata[2*PB+23:2*PB+8];

  // ---------------- storage ----------------
  logic [PB-1:0] src_mem [DEPTH];
  logic [PB-1:0] ref_mem [DEPTH];
  logic [15:0]   sp_mem  [SDEPTH];
  logic [SDEPTH-1:0] sp_vld_r;
  logic [15:0]   rg_mem  [RDEPTH];
  logic [RDEPTH-1:0] rg_vld_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [PB-1:0] src_rd_r, ref_rd_r;
  logic [SW-1:0] sp_raddr;
  logic [15:0]   sp_rd_r;
  logic [PB-1:0] rg_raddr;
  logic [15:0]   rg_rd_r;

  // ---------------- control registers ----------------
  state_t state_r, state_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [RW-1:0] in_ring_r, in_ring_nxt, out_ring_r, out_ring_nxt;
  logic [PB-1:0] src_r, ref_r;
  logic [1:0]    kind_r;
  logic [7:0]    idx_r;
  logic [15:0]   wt_r;
  logic [OFFW-1:0] dy_r, dy_nxt, dx_r, dx_nxt;
  logic [PB-1:0] pix_r, pix_nxt, rc_r, rc_nxt, tsrc_r, tsrc_nxt;
  logic [WSW-1:0] wsum_r, wsum_nxt;
  logic [ACW-1:0] acc_r, acc_nxt, rem_r, rem_nxt, quo_r, quo_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [DCW-1:0] bit_r, bit_nxt;
  logic          last_r, last_nxt, zw_r, zw_nxt;
  logic [PB-1:0] opix_r, opix_nxt;
  logic          olast_r, olast_nxt, ozw_r, ozw_nxt;

  // Ring row index of the tap row (out ring + dy - r, modulo RING).
  logic [RW+1:0] tap_ring_sum;
  logic [RW-1:0] tap_ring;
  logic [CW+1:0] tap_col_sum;
  logic [OFFW-1:0] ady, adx;
  logic [PB-1:0] diff;
  logic [ACW:0]  rem_try;
  logic [7:0]    mul_a;

  always_comb begin
    tap_ring_sum = (RW+2)'(out_ring_r) + (RW+2)'(dy_r) + (RW+2)'(RING) - (RW+2)'(eff_r);
    if (tap_ring_sum >= (RW+2)'(2*RING)) tap_ring = RW'(tap_ring_sum - (RW+2)'(2*RING));
    else if (tap_ring_sum >= (RW+2)'(RING)) tap_ring = RW'(tap_ring_sum - (RW+2)'(RING));
    else tap_ring = RW'(tap_ring_sum);
    tap_col_sum = (CW+2)'(out_col_r) + (CW+2)'(dx_r) - (CW+2)'(eff_r);
    ady = (dy_r >= OFFW'(eff_r)) ? dy_r - OFFW'(eff_r) : OFFW'(eff_r) - dy_r;
    adx = (dx_r >= OFFW'(eff_r)) ? dx_r - OFFW'(eff_r) : OFFW'(eff_r) - dx_r;
    diff = (rc_r > ref_rd_r) ? rc_r - ref_rd_r : ref_rd_r - rc_r;
    rem_try = {rem_r, acc_r[ACW-1]} - (ACW+1)'(wsum_r);
    mul_a = 8'(ady) * (8'(eff_r) + 8'd1) + 8'(adx);
  end

  // Line store ports: one write, one registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      src_mem[mem_waddr] <= src_r;
      ref_mem[mem_waddr] <= ref_r;
    end
    src_rd_r <= src_mem[mem_raddr];
    ref_rd_r <= ref_mem[mem_raddr];
  end

  // Weight tables: small memories with valid bits so that unloaded entries read zero.
  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE && kind_r == REQ_SPATIAL && 32'(idx_r) < SDEPTH)
      sp_mem[SW'(idx_r)] <= wt_r;
    if (state_r == ST_WRITE && kind_r == REQ_RANGE)
      rg_mem[PB'(idx_r)] <= wt_r;
    sp_rd_r <= sp_vld_r[sp_raddr] ? sp_mem[sp_raddr] : 16'd0;
    rg_rd_r <= rg_vld_r[rg_raddr] ? rg_mem[rg_raddr] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_vld_r <= '0;
      rg_vld_r <= '0;
    end else if (state_r == ST_WRITE) begin
      if (kind_r == REQ_SPATIAL && 32'(idx_r) < SDEPTH) sp_vld_r[SW'(idx_r)] <= 1'b1;
      if (kind_r == REQ_RANGE && 32'(idx_r) < RDEPTH) rg_vld_r[PB'(idx_r)] <= 1'b1;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      src_r  <= in_src;
      ref_r  <= in_ref;
      kind_r <= in_tuser;
      idx_r  <= in_idx;
      wt_r   <= in_wt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_DONE);
  assign out_tdata  = $bits(out_tdata)'(opix_r);
  assign out_tlast  = olast_r;
  assign out_tuser  = ozw_r;

  logic out_interior;
  assign out_interior = enable_r
      && out_row_r >= HW'(eff_r) && (out_row_r + HW'(eff_r)) < eff_h
      && (CW+1)'(out_col_r) >= (CW+1)'(eff_r)
      && ((CW+1)'(out_col_r) + (CW+1)'(eff_r)) < (CW+1)'(eff_w);

  // received count after the pixel write, compared with r*w + r
  logic [HW+MW:0] recv_cnt, lag_cnt;
  logic [CW:0]    col_inc;
  logic           in_wrap;

  always_comb begin
    col_inc  = (CW+1)'(in_col_r) + (CW+1)'(1);
    in_wrap  = col_inc >= (CW+1)'(eff_w);
    if (in_wrap) recv_cnt = (HW+MW+1)'(in_row_r + HW'(1)) * (HW+MW+1)'(eff_w);
    else recv_cnt = (HW+MW+1)'(in_row_r) * (HW+MW+1)'(eff_w) + (HW+MW+1)'(col_inc);
    lag_cnt = (HW+MW+1)'(eff_r) * (HW+MW+1)'(eff_w) + (HW+MW+1)'(eff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_ring_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_ring_r <= '0;
    end else begin
      state_r    <= state_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_ring_r  <= in_ring_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_ring_r <= out_ring_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dy_r <= dy_nxt;   dx_r <= dx_nxt;
    pix_r <= pix_nxt; rc_r <= rc_nxt; tsrc_r <= tsrc_nxt;
    wsum_r <= wsum_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    prod_r <= prod_nxt; bit_r <= bit_nxt;
    last_r <= last_nxt; zw_r <= zw_nxt;
    opix_r <= opix_nxt; olast_r <= olast_nxt; ozw_r <= ozw_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    in_col_nxt   = in_col_r;  in_row_nxt  = in_row_r;  in_ring_nxt  = in_ring_r;
    out_col_nxt  = out_col_r; out_row_nxt = out_row_r; out_ring_nxt = out_ring_r;
    dy_nxt = dy_r; dx_nxt = dx_r; pix_nxt = pix_r; rc_nxt = rc_r; tsrc_nxt = tsrc_r;
    wsum_nxt = wsum_r; acc_nxt = acc_r; rem_nxt = rem_r; quo_nxt = quo_r;
    prod_nxt = prod_r; bit_nxt = bit_r; last_nxt = last_r; zw_nxt = zw_r;
    opix_nxt = opix_r; olast_nxt = olast_r; ozw_nxt = ozw_r;
    mem_we    = 1'b0;
    mem_waddr = AW'(in_ring_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
    mem_raddr = AW'(out_ring_r) * AW'(MAX_WIDTH) + AW'(out_col_r);
    sp_raddr  = SW'(mul_a);
    rg_raddr  = diff;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
        if (kind_r == REQ_FLUSH) begin
          if (in_row_r >= eff_h && out_row_r < eff_h) state_nxt = ST_EMIT;
        end else if (kind_r == REQ_PIXEL && in_row_r < eff_h) begin
          mem_we = 1'b1;
          if (in_wrap) begin
            in_col_nxt  = '0;
            in_row_nxt  = in_row_r + HW'(1);
            in_ring_nxt = (in_ring_r == RW'(RING - 1)) ? '0 : in_ring_r + RW'(1);
          end else begin
            in_col_nxt = CW'(col_inc);
          end
          if (recv_cnt > lag_cnt) state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Line store read of the centre pixel is issued here.
        state_nxt = ST_CENTER;
      end
      ST_CENTER: begin
        pix_nxt  = src_rd_r;
        rc_nxt   = ref_rd_r;
        zw_nxt   = 1'b0;
        last_nxt = (out_row_r + HW'(1) >= eff_h) && ((CW+1)'(out_col_r) + 1 >= (CW+1)'(eff_w));
        dy_nxt   = '0;
        dx_nxt   = '0;
        wsum_nxt = '0;
        acc_nxt  = '0;
        state_nxt = out_interior ? ST_TAP_ADDR : ST_DONE;
        opix_nxt  = src_rd_r;
        olast_nxt = (out_row_r + HW'(1) >= eff_h) && ((CW+1)'(out_col_r) + 1 >= (CW+1)'(eff_w));
        ozw_nxt   = 1'b0;
      end
      ST_TAP_ADDR: begin
        mem_raddr = AW'(tap_ring) * AW'(MAX_WIDTH) + AW'(tap_col_sum[CW-1:0]);
        state_nxt = ST_TAP_READ;
      end
      ST_TAP_READ: begin
        // sp_raddr and rg_raddr are valid now; tables answer next cycle.
        tsrc_nxt  = src_rd_r;
        state_nxt = ST_TAP_RANGE;
      end
      ST_TAP_RANGE: begin
        prod_nxt  = 32'(sp_rd_r) * 32'(rg_rd_r);
        state_nxt = ST_TAP_MUL;
      end
      ST_TAP_MUL: begin
        wsum_nxt  = wsum_r + WSW'(prod_r[31:16]);
        prod_nxt  = 32'(prod_r[31:16]) * 32'(tsrc_r);
        state_nxt = ST_TAP_ACC;
      end
      ST_TAP_ACC: begin
        acc_nxt = acc_r + ACW'(prod_r);
        if (dx_r == OFFW'(2) * OFFW'(eff_r)) begin
          dx_nxt = '0;
          if (dy_r == OFFW'(2) * OFFW'(eff_r)) state_nxt = ST_DIV_INIT;
          else begin
            dy_nxt = dy_r + OFFW'(1);
            state_nxt = ST_TAP_ADDR;
          end
        end else begin
          dx_nxt = dx_r + OFFW'(1);
          state_nxt = ST_TAP_ADDR;
        end
      end
      ST_DIV_INIT: begin
        if (wsum_r == '0) begin
          ozw_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          acc_nxt   = acc_r + ACW'(wsum_r >> 1);
          rem_nxt   = '0;
          quo_nxt   = '0;
          bit_nxt   = DCW'(ACW);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        if (!rem_try[ACW]) begin
          rem_nxt = rem_try[ACW-1:0];
          quo_nxt = {quo_r[ACW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[ACW-2:0], acc_r[ACW-1]};
          quo_nxt = {quo_r[ACW-2:0], 1'b0};
        end
        acc_nxt = {acc_r[ACW-2:0], 1'b0};
        bit_nxt = bit_r - DCW'(1);
        if (bit_r == DCW'(1)) begin
          opix_nxt  = (quo_nxt > ACW'(PMAX)) ? PMAX : quo_nxt[PB-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            in_col_nxt = '0; in_row_nxt = '0; in_ring_nxt = '0;
            out_col_nxt = '0; out_row_nxt = '0; out_ring_nxt = '0;
          end else if ((CW+1)'(out_col_r) + 1 >= (CW+1)'(eff_w)) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + HW'(1);
            out_ring_nxt = (out_ring_r == RW'(RING - 1)) ? '0 : out_ring_r + RW'(1);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // A register write restarts the frame.
    if (cfg_hit) begin
      in_col_nxt = '0; in_row_nxt = '0; in_ring_nxt = '0;
      out_col_nxt = '0; out_row_nxt = '0; out_ring_nxt = '0;
    end
  end

  logic unused_pix;
  assign unused_pix = ^{pix_r, zw_r};

endmodule

/* test/tb_bilateral_filter_window_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilateral_filter_window_unit
// Self-checking bench: table loads, small frames at several radii and sizes,
// bypass, flushes and stray items, checked against a behavioral filter model.
// ----------------------------------------------------------------------------
module tb_bilateral_filter_window_unit;
  import bfw_pkg::*;

  localparam int RING = 2 * DEF_MAX_RADIUS + 1;
  localparam int SP_DEPTH = (DEF_MAX_RADIUS + 1) * (DEF_MAX_RADIUS + 1);

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic       zw;
  } pix_result_t;

  typedef struct {
    req_type_t   kind;
    logic [7:0]  src;
    logic [7:0]  rf;
    logic [7:0]  idx;
    logic [15:0] wv;
    logic        has_exp;
    pix_result_t exp_res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bilateral_filter_window_unit u_dut (.*);

  // Model state.
  logic [7:0]  m_src [RING*DEF_MAX_WIDTH];
  logic [7:0]  m_ref [RING*DEF_MAX_WIDTH];
  logic [15:0] m_spatial [SP_DEPTH];
  logic [15:0] m_range [256];
  int unsigned m_in_col, m_in_row, m_out_col, m_out_row;
  int unsigned m_radius, m_width, m_height, m_enable;

  pix_result_t pending_pixels[$];
  int          errors;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          frames_done;
  int          sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned ring_slot(int unsigned row, int unsigned col);
    return (row % RING) * DEF_MAX_WIDTH + (col % DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned eff_w();
    return (m_width < 1) ? 1 : (m_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : m_width);
  endfunction

  function automatic int unsigned eff_h();
    return (m_height < 1) ? 1 : (m_height > HEIGHT_LIMIT ? HEIGHT_LIMIT : m_height);
  endfunction

  function automatic pix_result_t filter_pixel();
    pix_result_t res;
    int unsigned r, w, h, row, col, ctr, rc, rn, diff, sidx, s, ay, ax;
    longint unsigned wsum, acc, wt, q;
    r = m_radius; w = eff_w(); h = eff_h();
    row = m_out_row; col = m_out_col;
    ctr = ring_slot(row, col);
    res.pixel = m_src[ctr];
    res.zw = 0;
    if (m_enable != 0 && row >= r && row + r < h && col >= r && col + r < w) begin
      rc = m_ref[ctr];
      wsum = 0; acc = 0;
      for (int ty = row - r; ty <= row + r; ty++) begin
        for (int tx = col - r; tx <= col + r; tx++) begin
          ay = (ty > row) ? ty - row : row - ty;
          ax = (tx > col) ? tx - col : col - tx;
          s = ring_slot(ty, tx);
          rn = m_ref[s];
          diff = (rc > rn) ? rc - rn : rn - rc;
          sidx = ay * (r + 1) + ax;
          wt = (longint'(m_spatial[sidx]) * m_range[diff]) >> 16;
          wsum += wt;
          acc += wt * m_src[s];
        end
      end
      if (wsum == 0) res.zw = 1;
      else begin
        q = (acc + wsum / 2) / wsum;
        res.pixel = (q > 255) ? 8'hFF : q[7:0];
      end
    end
    res.last = (row + 1 >= h) && (col + 1 >= w);
    if (res.last) begin
      m_in_col = 0; m_in_row = 0; m_out_col = 0; m_out_row = 0;
    end else begin
      m_out_col = col + 1;
      if (m_out_col >= w) begin
        m_out_col = 0;
        m_out_row = row + 1;
      end
    end
    return res;
  endfunction

  // Advances the model by one item; returns 1 with the result when one is due.
  function automatic bit predict_item(req_type_t kind, logic [7:0] src, logic [7:0] rf,
                                      logic [7:0] idx, logic [15:0] wv,
                                      output pix_result_t res);
    int unsigned s, w;
    res = '0;
    w = eff_w();
    case (kind)
      REQ_SPATIAL: begin
        if (idx < SP_DEPTH) m_spatial[idx] = wv;
        return 0;
      end
      REQ_RANGE: begin
        m_range[idx] = wv;
        return 0;
      end
      REQ_FLUSH: begin
        if (m_in_row >= eff_h() && m_out_row < eff_h()) begin
          res = filter_pixel();
          return 1;
        end
        return 0;
      end
      default: begin
        if (m_in_row >= eff_h()) return 0;
        s = ring_slot(m_in_row, m_in_col);
        m_src[s] = src;
        m_ref[s] = rf;
        m_in_col++;
        if (m_in_col >= w) begin
          m_in_col = 0;
          m_in_row++;
        end
        if (m_in_row * w + m_in_col > m_radius * w + m_radius) begin
          res = filter_pixel();
          return 1;
        end
        return 0;
      end
    endcase
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_pixels.size() == 0) begin
          $display("%t: unexpected result pixel=%0d last=%0b zw=%0b", $realtime,
                   out_tdata, out_tlast, out_tuser);
          errors++;
        end else begin
          pix_result_t e;
          e = pending_pixels.pop_front();
          if (e.pixel !== out_tdata || e.last !== out_tlast || e.zw !== out_tuser) begin
            $display("%t: expected pixel=%0d last=%0b zw=%0b, got pixel=%0d last=%0b zw=%0b",
                     $realtime, e.pixel, e.last, e.zw, out_tdata, out_tlast, out_tuser);
            errors++;
          end
          if (e.last) frames_done++;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(req_type_t kind, logic [7:0] src, logic [7:0] rf,
                           logic [7:0] idx, logic [15:0] wv,
                           bit has_exp = 0, pix_result_t exp_res = '0);
    pix_result_t res;
    // The block is busy in WRITE after each item anyway.
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {wv, idx, rf, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_item(kind, src, rf, idx, wv, res)) begin
      if (has_exp && res !== exp_res) begin
        $display("%t: table row expected pixel=%0d last=%0b zw=%0b, model pixel=%0d",
                 $realtime, exp_res.pixel, exp_res.last, exp_res.zw, res.pixel);
        errors++;
      end
      pending_pixels.push_back(res);
    end
    sent++;
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_pixels.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // Let a result-free item in flight finish.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t r, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {r, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (r)
      REG_RADIUS: m_radius = val[1:0];
      REG_WIDTH:  m_width  = val[10:0];
      REG_HEIGHT: m_height = val[12:0];
      default:    m_enable = val[0];
    endcase
    m_in_col = 0; m_in_row = 0; m_out_col = 0; m_out_row = 0;
  endtask

  task automatic set_frame(int unsigned r, int unsigned w, int unsigned h, bit en);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_ENABLE, en);
  endtask

  // A frame of mostly smooth content with occasional black or white edges and noise.
  task automatic random_frame(int unsigned npix);
    logic [7:0] base, s, rf;
    base = $urandom_range(255);
    for (int i = 0; i < npix; i++) begin
      case ($urandom_range(9))
        0: s = $urandom_range(255);
        1: s = ($urandom_range(1)) ? 8'hFF : 8'h00;
        default: s = base + $urandom_range(6) - 3;
      endcase
      rf = ($urandom_range(3) == 0) ? $urandom_range(255) : s;
      if ($urandom_range(39) == 0) begin
        if ($urandom_range(1)) send_item(REQ_FLUSH, $urandom, $urandom, $urandom, $urandom);
        else send_item(REQ_RANGE, 0, 0, $urandom_range(255), $urandom);
      end
      send_item(REQ_PIXEL, s, rf, $urandom, $urandom);
    end
    // Drain the lag, plus sometimes a stray pixel and extra flushes; a partial frame
    // only gets a couple of early flushes.
    if ($urandom_range(3) == 0) send_item(REQ_PIXEL, $urandom, $urandom, 0, 0);
    if (npix >= eff_w() * eff_h()) begin
      for (int i = 0; i < m_radius * eff_w() + m_radius + 2; i++)
        send_item(REQ_FLUSH, $urandom, $urandom, $urandom, $urandom);
    end else begin
      repeat (2) send_item(REQ_FLUSH, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  stim_row_t directed[$];

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = REQ_PIXEL;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    errors = 0; results_seen = 0; frames_done = 0; sent = 0;
    send_idle_pct = 21; recv_idle_pct = 85;
    foreach (m_src[i]) begin
      m_src[i] = 0;
      m_ref[i] = 0;
    end
    foreach (m_spatial[i]) m_spatial[i] = 0;
    foreach (m_range[i]) m_range[i] = 0;
    m_in_col = 0; m_in_row = 0; m_out_col = 0; m_out_row = 0;
    m_radius = 1; m_width = 1024; m_height = 768; m_enable = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: radius 1, 3x3 frame, tables all zero first.
    set_frame(1, 3, 3, 1);
    directed.push_back('{REQ_FLUSH, 8'd0, 8'd0, 8'd0, 16'd0, 0, '0});
    for (int i = 0; i < 9; i++)
      directed.push_back('{REQ_PIXEL, (i == 4) ? 8'hFF : 8'd0, 8'd0, 8'd0, 16'd0,
                           0, '0});
    directed.push_back('{REQ_PIXEL, 8'd9, 8'd9, 8'd0, 16'd0, 0, '0});
    directed.push_back('{REQ_FLUSH, 8'd0, 8'd0, 8'd0, 16'd0, 0, '0});
    directed.push_back('{REQ_FLUSH, 8'd0, 8'd0, 8'd0, 16'd0, 0, '0});
    directed.push_back('{REQ_FLUSH, 8'd0, 8'd0, 8'd0, 16'd0, 0, '0});
    directed.push_back('{REQ_FLUSH, 8'd0, 8'd0, 8'd0, 16'd0, 0, '0});
    directed.push_back('{REQ_SPATIAL, 8'd0, 8'd0, 8'd0, 16'hFFFF, 0, '0});
    directed.push_back('{REQ_SPATIAL, 8'd0, 8'd0, 8'd15, 16'h8000, 0, '0});
    directed.push_back('{REQ_SPATIAL, 8'd0, 8'd0, 8'd16, 16'h1234, 0, '0});
    directed.push_back('{REQ_SPATIAL, 8'd0, 8'd0, 8'hFF, 16'hFFFF, 0, '0});
    directed.push_back('{REQ_RANGE, 8'd0, 8'd0, 8'd0, 16'hFFFF, 0, '0});
    directed.push_back('{REQ_RANGE, 8'd0, 8'd0, 8'hFF, 16'd1, 0, '0});
    foreach (directed[i]) begin
      send_item(directed[i].kind, directed[i].src, directed[i].rf, directed[i].idx,
                directed[i].wv, directed[i].has_exp, directed[i].exp_res);
      // The last pixel of the frame releases the zero-weight center result.
      if (i == 9) begin
        pix_result_t zero_center;
        zero_center = '{pixel: 8'hFF, last: 1'b0, zw: 1'b1};
        if (pending_pixels.size() != 0 && pending_pixels[$] !== zero_center) begin
          $display("%t: expected pixel=255 last=0 zw=1, model pixel=%0d",
                   $realtime, pending_pixels[$].pixel);
          errors++;
        end
      end
    end

    // Random table contents, then frames under a spread of settings.
    for (int i = 0; i < SP_DEPTH; i++)
      send_item(REQ_SPATIAL, $urandom, $urandom, i, $urandom);
    for (int i = 0; i < 256; i += 1 + $urandom_range(3))
      send_item(REQ_RANGE, $urandom, $urandom, i, $urandom_range(65535));
    for (int ph = 0; sent < 800; ph++) begin
      int unsigned r, w, h;
      if (sent >= 540) begin send_idle_pct = 0; recv_idle_pct = 0; end
      else if (sent >= 270) begin send_idle_pct = 85; recv_idle_pct = 21; end
      case (ph % 6)
        0: begin r = 3; w = 7; h = 7; end
        1: begin r = 0; w = 1; h = 1; end
        2: begin r = 2; w = $urandom_range(5, 12); h = $urandom_range(5, 8); end
        3: begin r = 3; w = 1024; h = 1; end
        4: begin r = $urandom_range(3); w = 0; h = 0; end
        default: begin r = $urandom_range(3); w = $urandom_range(1, 10);
                       h = $urandom_range(1, 8); end
      endcase
      if (ph == 5) h = 4096;
      if (ph == 5) w = 1;
      set_frame(r, w, h, (ph % 7) != 3);
      random_frame(eff_w() * eff_h() > 200 ? 200 : eff_w() * eff_h());
    end

    drain();
    $display("Checked %0d output pixels over %0d complete frames, radius 0 to 3.",
             results_seen, frames_done);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
